### hdl/prt_fo_pkg.sv
// Shared constants, codes and result record for the pending request tracker.
package prt_fo_pkg;

	localparam int WINDOW_DEF     = 32;
	localparam int BODY_LIMIT_DEF = 255;
	localparam logic [15:0] DEAD_LIMIT_RST = 16'd1000;
	localparam logic [19:0] NS_PER_MS = 20'd1000000;

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_RESP = 2'd1;
	localparam logic [1:0] OP_LIVE = 2'd2;

	localparam logic [1:0] KIND_REQ    = 2'd0;
	localparam logic [1:0] KIND_ANSWER = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_DOWN = 3'd1;
	localparam logic [2:0] ST_LONG = 3'd2;
	localparam logic [2:0] ST_BUSY = 3'd3;
	localparam logic [2:0] ST_DUP  = 3'd4;

	localparam logic [1:0] CH_PRIMARY = 2'd0;
	localparam logic [1:0] CH_STANDBY = 2'd1;
	localparam logic [1:0] CH_NONE    = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic        chan;
		logic [63:0] tag;
		logic [63:0] pay;
		logic [7:0]  len;
		logic [2:0]  status;
		logic [5:0]  infl;
		logic [31:0] dup;
		logic [31:0] rep;
		logic [1:0]  act;
		logic        last;
	} res_t;

	// Build a single status-only result.
	function automatic res_t mk_status(input logic [2:0] st, input logic [5:0] infl,
			input logic [31:0] dup, input logic [31:0] rep, input logic [1:0] act);
		res_t r;
		r        = '0;
		r.kind   = KIND_STATUS;
		r.status = st;
		r.infl   = infl;
		r.dup    = dup;
		r.rep    = rep;
		r.act    = act;
		r.last   = 1'b1;
		return r;
	endfunction

endpackage

### hdl/pending_request_tracker_failover_top.sv
// Pending request tracker with one-time failover and replay, top level.
//
// channel   | direction | handshake                 | content
// s_axis    | in        | s_tvalid / s_tready       | one request, response or liveness beat
// m_axis    | out       | m_tvalid / m_tready       | result beats, m_tlast on the final one
// cfg       | in        | cfg_valid / cfg_ready     | dead_limit_ms, taken only while idle
//
// A response runs the tag-to-slot reduction, one memory read and one compare. On liveness,
// a failover walks the window to count the pending requests and, if it finds any, walks it
// again to replay them, each slot read and then checked on each pass.
// Reset clears the valid bits and counters at once; the slot memory needs no clearing.
// A new beat is taken only while the sequencer is idle and no configuration beat waits;
// a stalled result holds the walk.
module pending_request_tracker_failover_top #(
	parameter int WINDOW     = prt_fo_pkg::WINDOW_DEF,
	parameter int BODY_LIMIT = prt_fo_pkg::BODY_LIMIT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// operation[1:0], payload[65:2], length[73:66], response_tag[137:74],
	// now_time[201:138], heartbeat_time[265:202], zero fill
	input  logic [271:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// target_channel[0], tag[64:1], out_payload[128:65], out_length[136:129],
	// status[139:137], inflight_count[145:140], duplicate_count[177:146],
	// replay_count[209:178], active_channel[211:210], zero fill
	output logic [215:0] m_tdata,
	// result_kind[1:0]
	output logic [1:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ONE, S_MOD, S_RRD, S_RSP, S_AGE, S_LIV, S_WRD, S_WCK, S_WEND
	} state_t;

	state_t            state_q;
	prt_fo_pkg::res_t  out_q;
	logic              m_tvalid_q;

	logic [1:0]        op_q;
	logic [63:0]       pay_q;
	logic [7:0]        len_q;
	logic [63:0]       rtag_q;
	logic [63:0]       now_q;
	logic [63:0]       hb_q;
	logic [63:0]       age_q;
	logic [15:0]       dead_q;
	logic [63:0]       limit_q;

	logic [63:0]       next_tag_q;
	logic [SW-1:0]     next_slot_q;
	logic [WINDOW-1:0] used_q;
	logic [1:0]        chan_q;
	logic              fo_done_q;
	logic [5:0]        infl_q;
	logic [31:0]       dup_q;
	logic [31:0]       rep_q;

	logic [63:0]       tsh_q;
	logic [SW-1:0]     rem_q;
	logic [2:0]        mcnt_q;
	logic [SW-1:0]     slot_q;

	logic [SW-1:0]     idx_q;
	logic [SW-1:0]     start_q;
	logic [63:0]       c_q;
	logic [63:0]       first_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     span_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     k_q;
	logic              pass_q;
	logic              hit_used_q;

	// slot memory: tag, payload, length
	logic [135:0]      mem [WINDOW];
	logic [135:0]      rdata_q;
	logic [SW-1:0]     rd_addr;
	logic              wr_en;

	logic              ofree;
	logic              down;
	logic [SW:0]       rem_next;
	logic              walk_hit;

	assign s_tready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign ofree     = !m_tvalid_q || m_tready;
	assign down      = (chan_q == prt_fo_pkg::CH_NONE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = out_q.kind;
	assign m_tlast   = out_q.last;
	assign m_tdata   = {4'd0, out_q.act, out_q.rep, out_q.dup, out_q.infl, out_q.status,
		out_q.len, out_q.pay, out_q.tag, out_q.chan};

	// hold the walk address while a replay beat waits for the receiver
	assign rd_addr  = (state_q == S_WRD || state_q == S_WCK) ? idx_q : slot_q;
	assign wr_en    = (state_q == S_ONE) && ofree && (op_q == prt_fo_pkg::OP_SEND) && !down
		&& (len_q <= 8'(BODY_LIMIT)) && !used_q[next_slot_q];
	assign walk_hit = hit_used_q && (rdata_q[135:72] == c_q);

	// Reduce eight tag bits per cycle into the slot remainder
	always_comb begin
		rem_next = {1'b0, rem_q};
		for (int b = 0; b < 8; b++) begin
			rem_next = {rem_next[SW-1:0], tsh_q[63-b]};
			if (rem_next >= (SW+1)'(WINDOW)) begin
				rem_next = rem_next - (SW+1)'(WINDOW);
			end
		end
	end

	// Slot memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[next_slot_q] <= {next_tag_q, pay_q, len_q};
		end
		rdata_q <= mem[rd_addr];
	end

	// Heartbeat limit in nanoseconds
	always_ff @(posedge clk) begin
		limit_q <= 64'(dead_q) * 64'(prt_fo_pkg::NS_PER_MS);
	end

	// Sequencer, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			m_tvalid_q  <= 1'b0;
			dead_q      <= prt_fo_pkg::DEAD_LIMIT_RST;
			next_tag_q  <= '0;
			next_slot_q <= '0;
			used_q      <= '0;
			chan_q      <= prt_fo_pkg::CH_PRIMARY;
			fo_done_q   <= 1'b0;
			infl_q      <= '0;
			dup_q       <= '0;
			rep_q       <= '0;
		end else begin
			logic emit_v;
			emit_v = 1'b0;
			if (cfg_valid && cfg_ready) begin
				dead_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q   <= s_tdata[1:0];
						pay_q  <= s_tdata[65:2];
						len_q  <= s_tdata[73:66];
						rtag_q <= s_tdata[137:74];
						now_q  <= s_tdata[201:138];
						hb_q   <= s_tdata[265:202];
						tsh_q  <= s_tdata[137:74];
						rem_q  <= '0;
						mcnt_q <= '0;
						case (s_tdata[1:0])
							prt_fo_pkg::OP_RESP: state_q <= S_MOD;
							prt_fo_pkg::OP_LIVE: state_q <= S_AGE;
							default:             state_q <= S_ONE;
						endcase
					end
				end
				// send, or an unknown operation
				S_ONE: begin
					if (ofree) begin
						emit_v  = 1'b1;
						state_q <= S_IDLE;
						if (op_q != prt_fo_pkg::OP_SEND) begin
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_OK, infl_q,
								dup_q, rep_q, chan_q);
						end else if (down) begin
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_DOWN, infl_q,
								dup_q, rep_q, chan_q);
						end else if (len_q > 8'(BODY_LIMIT)) begin
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_LONG, infl_q,
								dup_q, rep_q, chan_q);
						end else if (used_q[next_slot_q]) begin
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_BUSY, infl_q,
								dup_q, rep_q, chan_q);
						end else begin
							used_q[next_slot_q] <= 1'b1;
							infl_q       <= infl_q + 6'd1;
							next_tag_q   <= next_tag_q + 64'd1;
							next_slot_q  <= (next_slot_q == SW'(WINDOW - 1)) ? '0
								: next_slot_q + SW'(1);
							out_q.kind   <= prt_fo_pkg::KIND_REQ;
							out_q.chan   <= chan_q[0];
							out_q.tag    <= next_tag_q;
							out_q.pay    <= pay_q;
							out_q.len    <= len_q;
							out_q.status <= prt_fo_pkg::ST_OK;
							out_q.infl   <= infl_q + 6'd1;
							out_q.dup    <= dup_q;
							out_q.rep    <= rep_q;
							out_q.act    <= chan_q;
							out_q.last   <= 1'b1;
						end
					end
				end
				// response tag modulo window
				S_MOD: begin
					rem_q  <= rem_next[SW-1:0];
					tsh_q  <= {tsh_q[55:0], 8'd0};
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd7) begin
						slot_q  <= rem_next[SW-1:0];
						state_q <= S_RRD;
					end
				end
				S_RRD: state_q <= S_RSP;
				S_RSP: begin
					if (ofree) begin
						emit_v  = 1'b1;
						state_q <= S_IDLE;
						if (down) begin
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_DOWN, infl_q,
								dup_q, rep_q, chan_q);
						end else if (used_q[slot_q] && rdata_q[135:72] == rtag_q) begin
							used_q[slot_q] <= 1'b0;
							infl_q       <= infl_q - 6'd1;
							out_q.kind   <= prt_fo_pkg::KIND_ANSWER;
							out_q.chan   <= 1'b0;
							out_q.tag    <= rtag_q;
							out_q.pay    <= pay_q;
							out_q.len    <= len_q;
							out_q.status <= prt_fo_pkg::ST_OK;
							out_q.infl   <= infl_q - 6'd1;
							out_q.dup    <= dup_q;
							out_q.rep    <= rep_q;
							out_q.act    <= chan_q;
							out_q.last   <= 1'b1;
						end else begin
							dup_q <= dup_q + 32'd1;
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_DUP, infl_q,
								dup_q + 32'd1, rep_q, chan_q);
						end
					end
				end
				S_AGE: begin
					age_q   <= now_q - hb_q;
					state_q <= S_LIV;
				end
				S_LIV: begin
					if (down) begin
						if (ofree) begin
							emit_v  = 1'b1;
							state_q <= S_IDLE;
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_DOWN, infl_q,
								dup_q, rep_q, chan_q);
						end
					end else if (hb_q == 64'd0 || age_q <= limit_q) begin
						if (ofree) begin
							emit_v  = 1'b1;
							state_q <= S_IDLE;
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_OK, infl_q,
								dup_q, rep_q, chan_q);
						end
					end else if (fo_done_q) begin
						if (ofree) begin
							emit_v  = 1'b1;
							state_q <= S_IDLE;
							chan_q  <= prt_fo_pkg::CH_NONE;
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_DOWN, infl_q,
								dup_q, rep_q, prt_fo_pkg::CH_NONE);
						end
					end else begin
						// first failover: switch over and start the counting pass
						fo_done_q <= 1'b1;
						chan_q    <= (chan_q == prt_fo_pkg::CH_PRIMARY)
							? prt_fo_pkg::CH_STANDBY : prt_fo_pkg::CH_PRIMARY;
						pass_q    <= 1'b0;
						cnt_q     <= '0;
						k_q       <= '0;
						i_q       <= '0;
						if (next_tag_q < 64'(WINDOW)) begin
							span_q  <= CW'(next_tag_q);
							first_q <= '0;
							c_q     <= '0;
							start_q <= '0;
							idx_q   <= '0;
						end else begin
							span_q  <= CW'(WINDOW);
							first_q <= next_tag_q - 64'(WINDOW);
							c_q     <= next_tag_q - 64'(WINDOW);
							start_q <= next_slot_q;
							idx_q   <= next_slot_q;
						end
						state_q <= S_WRD;
					end
				end
				// window walk: read one slot
				S_WRD: begin
					if (i_q == span_q) begin
						state_q <= S_WEND;
					end else begin
						hit_used_q <= used_q[idx_q];
						state_q    <= S_WCK;
					end
				end
				S_WCK: begin
					if (!pass_q || !walk_hit || ofree) begin
						if (!pass_q) begin
							cnt_q <= cnt_q + CW'(walk_hit);
						end else if (walk_hit) begin
							emit_v = 1'b1;
							k_q          <= k_q + CW'(1);
							out_q.kind   <= prt_fo_pkg::KIND_REQ;
							out_q.chan   <= chan_q[0];
							out_q.tag    <= c_q;
							out_q.pay    <= rdata_q[71:8];
							out_q.len    <= rdata_q[7:0];
							out_q.status <= prt_fo_pkg::ST_OK;
							out_q.infl   <= infl_q;
							out_q.dup    <= dup_q;
							out_q.rep    <= rep_q;
							out_q.act    <= chan_q;
							out_q.last   <= (k_q + CW'(1) == cnt_q);
						end
						i_q     <= i_q + CW'(1);
						c_q     <= c_q + 64'd1;
						idx_q   <= (idx_q == SW'(WINDOW - 1)) ? '0 : idx_q + SW'(1);
						state_q <= S_WRD;
					end
				end
				S_WEND: begin
					if (pass_q) begin
						state_q <= S_IDLE;
					end else if (cnt_q == '0) begin
						if (ofree) begin
							emit_v  = 1'b1;
							state_q <= S_IDLE;
							out_q <= prt_fo_pkg::mk_status(prt_fo_pkg::ST_OK, infl_q,
								dup_q, rep_q, chan_q);
						end
					end else begin
						// replay pass: counter already holds its final value
						rep_q   <= rep_q + 32'(cnt_q);
						pass_q  <= 1'b1;
						i_q     <= '0;
						c_q     <= first_q;
						idx_q   <= start_q;
						state_q <= S_WRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// load a new beat, or drop the one just taken
			m_tvalid_q <= emit_v || (m_tvalid_q && !m_tready);
		end
	end

`ifndef ASSERT_OFF
	a_infl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		infl_q <= 6'(WINDOW))
		else $error("inflight count beyond window");
	a_none_after_fo: assert property (@(posedge clk) disable iff (!arst_n)
		(chan_q == prt_fo_pkg::CH_NONE) |-> fo_done_q)
		else $error("router down without prior failover");
	a_replay_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WCK) |-> (k_q <= cnt_q))
		else $error("more replays than counted");
	a_walk_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WEND && pass_q) |-> (k_q == cnt_q))
		else $error("replay pass emitted wrong number of beats");
`endif

endmodule

### bench/pending_request_tracker_failover_top_tb.sv
// Self-checking bench for the pending request tracker with failover and replay.
`timescale 1ns / 100ps

module pending_request_tracker_failover_top_tb;

	localparam int WIN        = prt_fo_pkg::WINDOW_DEF;
	localparam int SETTLE_CYC = 4 * prt_fo_pkg::WINDOW_DEF + 40;
	localparam int HOLD_CYC   = 300;
	localparam int PHASE_ITEMS = 115;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [271:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [215:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] pay;
		logic [7:0]  len;
		logic [63:0] rtag;
		logic [63:0] now;
		logic [63:0] hb;
		bit          typed;
		prt_fo_pkg::res_t want;
	} dir_row_t;

	// tracker copy
	logic [63:0] trk_next_tag;
	bit          trk_used [WIN];
	logic [63:0] trk_tag [WIN];
	logic [63:0] trk_pay [WIN];
	logic [7:0]  trk_len [WIN];
	logic [1:0]  trk_chan;
	bit          trk_failed_over;
	logic [5:0]  trk_inflight;
	logic [31:0] trk_dups;
	logic [31:0] trk_replays;
	logic [15:0] trk_dead_ms;

	prt_fo_pkg::res_t expected_beats[$];
	int       fail_cnt;
	bit       hold_req;
	dir_row_t dir_rows[$];

	pending_request_tracker_failover_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("pending_request_tracker_failover_top test failed");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic prt_fo_pkg::res_t beat(logic [1:0] kind, logic chan,
			logic [63:0] tag, logic [63:0] pay, logic [7:0] len, logic [2:0] st,
			logic [5:0] infl, logic [31:0] dup);
		prt_fo_pkg::res_t r;
		r        = '0;
		r.kind   = kind;
		r.chan   = chan;
		r.tag    = tag;
		r.pay    = pay;
		r.len    = len;
		r.status = st;
		r.infl   = infl;
		r.dup    = dup;
		r.act    = prt_fo_pkg::CH_PRIMARY;
		r.last   = 1'b1;
		return r;
	endfunction

	// Work out the result beats of one accepted item and queue them.
	task automatic track_item(input logic [1:0] op, input logic [63:0] pay,
			input logic [7:0] len, input logic [63:0] rtag, input logic [63:0] now,
			input logic [63:0] hb, output prt_fo_pkg::res_t beats[$]);
		int          s;
		bit          down;
		logic [63:0] lim;
		logic [63:0] span;
		logic [63:0] c;
		prt_fo_pkg::res_t r;
		beats = {};
		down  = (trk_chan > prt_fo_pkg::CH_STANDBY);
		lim   = 64'(trk_dead_ms) * 64'd1000000;
		r     = beat(prt_fo_pkg::KIND_STATUS, 1'b0, '0, '0, '0, prt_fo_pkg::ST_OK, '0, '0);
		case (op)
			prt_fo_pkg::OP_SEND: begin
				s = int'(trk_next_tag % WIN);
				if (down) begin
					r.status = prt_fo_pkg::ST_DOWN;
				end else if (len > prt_fo_pkg::BODY_LIMIT_DEF) begin
					r.status = prt_fo_pkg::ST_LONG;
				end else if (trk_used[s]) begin
					r.status = prt_fo_pkg::ST_BUSY;
				end else begin
					trk_used[s]  = 1'b1;
					trk_tag[s]   = trk_next_tag;
					trk_pay[s]   = pay;
					trk_len[s]   = len;
					trk_inflight = trk_inflight + 6'd1;
					r = beat(prt_fo_pkg::KIND_REQ, trk_chan[0], trk_next_tag, pay, len,
						prt_fo_pkg::ST_OK, '0, '0);
					trk_next_tag = trk_next_tag + 64'd1;
				end
				beats.push_back(r);
			end
			prt_fo_pkg::OP_RESP: begin
				s = int'(rtag % WIN);
				if (down) begin
					r.status = prt_fo_pkg::ST_DOWN;
				end else if (trk_used[s] && trk_tag[s] == rtag) begin
					trk_used[s]  = 1'b0;
					trk_inflight = trk_inflight - 6'd1;
					r = beat(prt_fo_pkg::KIND_ANSWER, 1'b0, rtag, pay, len,
						prt_fo_pkg::ST_OK, '0, '0);
				end else begin
					trk_dups = trk_dups + 32'd1;
					r.status = prt_fo_pkg::ST_DUP;
				end
				beats.push_back(r);
			end
			prt_fo_pkg::OP_LIVE: begin
				if (down) begin
					r.status = prt_fo_pkg::ST_DOWN;
				end else if (hb == 0 || now - hb <= lim) begin
					r.status = prt_fo_pkg::ST_OK;
				end else if (trk_failed_over) begin
					trk_chan = prt_fo_pkg::CH_NONE;
					r.status = prt_fo_pkg::ST_DOWN;
				end else begin
					// replay every unanswered request, oldest first
					trk_failed_over = 1'b1;
					trk_chan = (trk_chan == prt_fo_pkg::CH_PRIMARY)
						? prt_fo_pkg::CH_STANDBY : prt_fo_pkg::CH_PRIMARY;
					span = (trk_next_tag < WIN) ? trk_next_tag : 64'(WIN);
					for (logic [63:0] i = 0; i < span; i++) begin
						c = trk_next_tag - span + i;
						s = int'(c % WIN);
						if (trk_used[s] && trk_tag[s] == c) begin
							beats.push_back(beat(prt_fo_pkg::KIND_REQ, trk_chan[0], c,
								trk_pay[s], trk_len[s], prt_fo_pkg::ST_OK, '0, '0));
							trk_replays = trk_replays + 32'd1;
						end
					end
				end
				if (beats.size() == 0)
					beats.push_back(r);
			end
			default: begin
				beats.push_back(r);
			end
		endcase
		// stamp end-of-step counters on every beat
		foreach (beats[k]) begin
			beats[k].infl = trk_inflight;
			beats[k].dup  = trk_dups;
			beats[k].rep  = trk_replays;
			beats[k].act  = trk_chan;
			beats[k].last = (k == beats.size() - 1);
		end
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s mismatch, got %0h expected %0h", $realtime, field, got, want);
		fail_cnt++;
	endtask

	// Offer one item, hold until taken, then queue its expected beats.
	task automatic offer_item(input logic [1:0] op, input logic [63:0] pay,
			input logic [7:0] len, input logic [63:0] rtag, input logic [63:0] now,
			input logic [63:0] hb, input bit typed, input prt_fo_pkg::res_t want);
		prt_fo_pkg::res_t beats[$];
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, hb, now, rtag, len, pay, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_item(op, pay, len, rtag, now, hb, beats);
		if (typed)
			beats[0] = want;
		foreach (beats[k])
			expected_beats.push_back(beats[k]);
	endtask

	// Random gap after a burst of beats.
	int burst_left;
	task automatic maybe_gap();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
			burst_left = $urandom_range(0, 20);
		end
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC)
			@(posedge clk);
	endtask

	task automatic write_dead_limit(input logic [15:0] ms);
		cfg_valid <= 1'b1;
		cfg_data  <= ms;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid   <= 1'b0;
		trk_dead_ms = ms;
	endtask

	// One random item; stale asks for a dead heartbeat.
	task automatic random_item(input bit stale);
		logic [1:0]  op;
		logic [63:0] pay, rtag, now, hb, lim, age;
		logic [7:0]  len;
		int          pick, used_idx[$];
		pay  = rand64();
		len  = 8'($urandom);
		rtag = rand64();
		now  = rand64();
		hb   = rand64();
		lim  = 64'(trk_dead_ms) * 64'd1000000;
		pick = $urandom_range(0, 99);
		foreach (trk_used[i])
			if (trk_used[i])
				used_idx.push_back(i);
		if (stale) begin
			op  = prt_fo_pkg::OP_LIVE;
			if (hb == 0)
				hb = 64'd1;
			age = lim + 64'd1 + 64'($urandom);
			now = hb + age;
		end else if (pick < 48) begin
			op = prt_fo_pkg::OP_SEND;
		end else if (pick < 82) begin
			op = prt_fo_pkg::OP_RESP;
			if (used_idx.size() != 0)
				rtag = trk_tag[used_idx[$urandom_range(0, used_idx.size() - 1)]];
		end else if (pick < 88) begin
			// late answer to a recently issued tag, or a random one
			op = prt_fo_pkg::OP_RESP;
			if (pick < 85)
				rtag = trk_next_tag - 64'($urandom_range(1, 40));
		end else if (pick < 97) begin
			op = prt_fo_pkg::OP_LIVE;
			if (pick < 90) begin
				hb = '0;
			end else begin
				age = (lim == '0) ? '0 : rand64() % (lim + 64'd1);
				now = hb + age;
			end
		end else begin
			op = 2'd3;
		end
		offer_item(op, pay, len, rtag, now, hb, 1'b0, '0);
	endtask

	// Receiver: stall pattern of its own, plus one long hold-off on request.
	initial begin
		bit held;
		int mode;
		held = 1'b0;
		mode = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				m_tready <= 1'b0;
				held = 1'b1;
				repeat (HOLD_CYC)
					@(posedge clk);
			end else begin
				if ($urandom_range(0, 63) == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Check every result beat against the oldest expectation.
	always @(posedge clk) begin
		prt_fo_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: result beat with nothing expected", $realtime);
				fail_cnt++;
			end else begin
				want = expected_beats.pop_front();
				if (m_tuser != want.kind)
					report_mismatch("result_kind", 64'(m_tuser), 64'(want.kind));
				if (m_tdata[0] != want.chan)
					report_mismatch("target_channel", 64'(m_tdata[0]), 64'(want.chan));
				if (m_tdata[64:1] != want.tag)
					report_mismatch("tag", m_tdata[64:1], want.tag);
				if (m_tdata[128:65] != want.pay)
					report_mismatch("out_payload", m_tdata[128:65], want.pay);
				if (m_tdata[136:129] != want.len)
					report_mismatch("out_length", 64'(m_tdata[136:129]), 64'(want.len));
				if (m_tdata[139:137] != want.status)
					report_mismatch("status", 64'(m_tdata[139:137]), 64'(want.status));
				if (m_tdata[145:140] != want.infl)
					report_mismatch("inflight_count", 64'(m_tdata[145:140]), 64'(want.infl));
				if (m_tdata[177:146] != want.dup)
					report_mismatch("duplicate_count", 64'(m_tdata[177:146]), 64'(want.dup));
				if (m_tdata[209:178] != want.rep)
					report_mismatch("replay_count", 64'(m_tdata[209:178]), 64'(want.rep));
				if (m_tdata[211:210] != want.act)
					report_mismatch("active_channel", 64'(m_tdata[211:210]), 64'(want.act));
				if (m_tlast != want.last)
					report_mismatch("last", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	function automatic dir_row_t row(logic [1:0] op, logic [63:0] pay, logic [7:0] len,
			logic [63:0] rtag, logic [63:0] now, logic [63:0] hb, bit typed,
			prt_fo_pkg::res_t want);
		dir_row_t d;
		d.op = op; d.pay = pay; d.len = len; d.rtag = rtag;
		d.now = now; d.hb = hb; d.typed = typed; d.want = want;
		return d;
	endfunction

	// Main sequence: reset, directed rows, then random phases at several limits.
	initial begin
		logic [63:0] ones;
		logic [15:0] limits[4];
		int          stale_at;
		ones = '1;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		hold_req  = 1'b0;
		fail_cnt  = 0;
		burst_left = 0;
		trk_next_tag = '0;
		foreach (trk_used[i]) begin
			trk_used[i] = 1'b0;
			trk_tag[i]  = '0;
			trk_pay[i]  = '0;
			trk_len[i]  = '0;
		end
		trk_chan        = prt_fo_pkg::CH_PRIMARY;
		trk_failed_over = 1'b0;
		trk_inflight    = '0;
		trk_dups        = '0;
		trk_replays     = '0;
		trk_dead_ms     = prt_fo_pkg::DEAD_LIMIT_RST;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: field extremes, every operation, fresh and edge ages
		dir_rows.push_back(row(prt_fo_pkg::OP_SEND, '0, 8'd0, '0, '0, '0, 1'b1,
			beat(prt_fo_pkg::KIND_REQ, 1'b0, 64'd0, '0, 8'd0, prt_fo_pkg::ST_OK,
			6'd1, 32'd0)));
		dir_rows.push_back(row(prt_fo_pkg::OP_SEND, ones, 8'd255, '0, '0, '0, 1'b1,
			beat(prt_fo_pkg::KIND_REQ, 1'b0, 64'd1, ones, 8'd255, prt_fo_pkg::ST_OK,
			6'd2, 32'd0)));
		dir_rows.push_back(row(prt_fo_pkg::OP_RESP, ones, 8'd255, 64'd0, '0, '0, 1'b1,
			beat(prt_fo_pkg::KIND_ANSWER, 1'b0, 64'd0, ones, 8'd255, prt_fo_pkg::ST_OK,
			6'd1, 32'd0)));
		dir_rows.push_back(row(prt_fo_pkg::OP_RESP, '0, 8'd0, 64'd0, '0, '0, 1'b1,
			beat(prt_fo_pkg::KIND_STATUS, 1'b0, '0, '0, '0, prt_fo_pkg::ST_DUP,
			6'd1, 32'd1)));
		dir_rows.push_back(row(prt_fo_pkg::OP_RESP, ones, 8'd255, ones, '0, '0, 1'b1,
			beat(prt_fo_pkg::KIND_STATUS, 1'b0, '0, '0, '0, prt_fo_pkg::ST_DUP,
			6'd1, 32'd2)));
		dir_rows.push_back(row(prt_fo_pkg::OP_LIVE, '0, 8'd0, '0, ones, '0, 1'b1,
			beat(prt_fo_pkg::KIND_STATUS, 1'b0, '0, '0, '0, prt_fo_pkg::ST_OK,
			6'd1, 32'd2)));
		dir_rows.push_back(row(2'd3, ones, 8'd255, ones, ones, ones, 1'b1,
			beat(prt_fo_pkg::KIND_STATUS, 1'b0, '0, '0, '0, prt_fo_pkg::ST_OK,
			6'd1, 32'd2)));
		dir_rows.push_back(row(prt_fo_pkg::OP_SEND, 64'd5, 8'd7, '0, '0, '0, 1'b0, '0));
		// tag that maps to a busy slot but does not match it
		dir_rows.push_back(row(prt_fo_pkg::OP_RESP, 64'd9, 8'd3, 64'd34, '0, '0, 1'b0, '0));
		dir_rows.push_back(row(prt_fo_pkg::OP_LIVE, '0, 8'd0, '0, ones, ones, 1'b0, '0));
		// age exactly at the limit is still fresh
		dir_rows.push_back(row(prt_fo_pkg::OP_LIVE, '0, 8'd0, '0, 64'd1000000007, 64'd7,
			1'b0, '0));
		dir_rows.push_back(row(prt_fo_pkg::OP_LIVE, '0, 8'd0, '0, 64'd5000000000,
			64'd4500000000, 1'b0, '0));
		dir_rows.push_back(row(prt_fo_pkg::OP_RESP, 64'h8000_0000_0000_0001, 8'd128, 64'd1,
			'0, '0, 1'b0, '0));
		dir_rows.push_back(row(prt_fo_pkg::OP_RESP, '0, 8'd0, 64'd2, '0, '0, 1'b0, '0));
		foreach (dir_rows[i]) begin
			offer_item(dir_rows[i].op, dir_rows[i].pay, dir_rows[i].len, dir_rows[i].rtag,
				dir_rows[i].now, dir_rows[i].hb, dir_rows[i].typed, dir_rows[i].want);
			maybe_gap();
		end

		// random phases; first failover in the third, router down late in the last
		limits[0] = 16'd0;
		limits[1] = 16'd1;
		limits[2] = 16'hFFFF;
		limits[3] = 16'($urandom);
		for (int ph = 0; ph < 4; ph++) begin
			drain_and_settle();
			write_dead_limit(limits[ph]);
			stale_at = (ph == 2) ? $urandom_range(40, 90) :
				(ph == 3) ? PHASE_ITEMS - 20 : -1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 30)
					hold_req = 1'b1;
				random_item(n == stale_at);
				maybe_gap();
			end
		end

		drain_and_settle();
		if (fail_cnt == 0)
			$display("pending_request_tracker_failover_top test passed");
		else
			$display("pending_request_tracker_failover_top test failed");
		$finish;
	end

	// A runaway backlog of expectations counts as a failure.
	always @(posedge clk)
		if (arst_n && fail_cnt == 0 && expected_beats.size() > 4000)
			fail_cnt++;

endmodule

### pending_request_tracker_failover_top.f
hdl/prt_fo_pkg.sv
hdl/pending_request_tracker_failover_top.sv
bench/pending_request_tracker_failover_top_tb.sv
